// ===== hdl/trs_pkg.sv =====
// Shared types and constants of the reservation station scheduler.
package trs_pkg;

	localparam int DW         = 32;
	localparam int NREG       = 32;
	localparam int REG_W      = 5;
	localparam int ADD_ST     = 4;
	localparam int MUL_ST     = 2;
	localparam int DIV_ST     = 3;
	localparam int NSTA       = ADD_ST + MUL_ST + DIV_ST;
	localparam int IDX_W      = $clog2(NSTA);
	localparam int LAT_W      = 6;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);

	typedef logic [3:0] tag_t;

	localparam tag_t TAG_READY = tag_t'(NSTA);
	localparam tag_t TAG_EMPTY = tag_t'(NSTA + 1);

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_NONE   = 2'd0;
	localparam logic [1:0] ST_STALL  = 2'd1;
	localparam logic [1:0] ST_ISSUED = 2'd2;

	localparam logic KIND_ISSUE = 1'b0;
	localparam logic KIND_WB    = 1'b1;

	localparam logic [1:0] CFG_ADD_LAT = 2'd0;
	localparam logic [1:0] CFG_MUL_LAT = 2'd1;
	localparam logic [1:0] CFG_DIV_LAT = 2'd2;

	typedef enum logic [1:0] {
		CLS_ADD,
		CLS_MUL,
		CLS_DIV
	} cls_t;

	typedef struct packed {
		logic             vld;
		logic [1:0]       op;
		cls_t             cls;
		logic [REG_W-1:0] dest;
		logic [REG_W-1:0] src1;
		logic [REG_W-1:0] src2;
	} item_t;

	typedef struct packed {
		logic             we;
		logic [1:0]       index;
		logic [LAT_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== hdl/trs_front.sv =====
// Front end: takes input transfers and classifies each instruction by station class.
module trs_front import trs_pkg::*; (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             instr_valid,
	input  logic [1:0]       opcode,
	input  logic [REG_W-1:0] dest_reg,
	input  logic [REG_W-1:0] src1_reg,
	input  logic [REG_W-1:0] src2_reg,
	output logic             push_valid,
	input  logic             push_ready,
	output item_t            push_item
);

	cls_t cls;

	always_comb begin
		case (opcode)
			OP_ADD, OP_SUB: cls = CLS_ADD;
			OP_MUL:         cls = CLS_MUL;
			default:        cls = CLS_DIV;
		endcase
	end

	assign push_valid     = in_valid;
	assign in_ready       = push_ready;
	assign push_item.vld  = instr_valid;
	assign push_item.op   = opcode;
	assign push_item.cls  = cls;
	assign push_item.dest = dest_reg;
	assign push_item.src1 = src1_reg;
	assign push_item.src2 = src2_reg;

endmodule

// ===== hdl/trs_queue.sv =====
// Short queue of classified items between the front end and the sequencer.
module trs_queue import trs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign push_ready = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/trs_div.sv =====
// Iterative signed divider, one quotient bit a cycle; divide by zero gives zero.
module trs_div import trs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic          done,
	output logic [DW-1:0] q
);

	localparam int CNT_W = $clog2(DW);

	logic [DW-1:0]    dvd_q, dsr_q, rem_q;
	logic             neg_q, zero_q, run_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW:0]      trial;
	logic [DW-1:0]    ma, mb;

	assign ma    = a[DW-1] ? (~a + 1'b1) : a;
	assign mb    = b[DW-1] ? (~b + 1'b1) : b;
	assign trial = {rem_q, dvd_q[DW-1]} - {1'b0, dsr_q};
	assign done  = done_q;
	assign q     = zero_q ? '0 : (neg_q ? (~dvd_q + 1'b1) : dvd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DW - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= ma;
			dsr_q  <= mb;
			rem_q  <= '0;
			neg_q  <= a[DW-1] ^ b[DW-1];
			zero_q <= b == '0;
		end else if (run_q) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], dvd_q[DW-1]};
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== hdl/trs_back.sv =====
// Back end: sequencer that issues, executes and broadcasts over the stations.
module trs_back import trs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_wr_t              cfg,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  item_t                pop_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 record_kind,
	output logic [1:0]           issue_status,
	output logic [3:0]           station,
	output logic signed [DW-1:0] value,
	output logic                 last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_RD1,
		S_RD2,
		S_EXEC,
		S_MUL,
		S_DIVW,
		S_WB
	} state_t;

	state_t           state_q;
	item_t            cur_q;
	logic [IDX_W-1:0] idx_q;
	tag_t             free_q;
	logic             div_start_q;
	logic [DW-1:0]    mul_s1;
	logic [LAT_W-1:0] add_lat_q, mul_lat_q, div_lat_q;

	logic             busy_q [NSTA];
	logic [1:0]       op_q   [NSTA];
	logic [DW-1:0]    opj_q  [NSTA];
	logic [DW-1:0]    opk_q  [NSTA];
	tag_t             tj_q   [NSTA];
	tag_t             tk_q   [NSTA];
	logic [LAT_W-1:0] cnt_q  [NSTA];
	logic             iw_q   [NSTA];
	logic             rr_q   [NSTA];
	logic             ww_q   [NSTA];
	logic [DW-1:0]    res_q  [NSTA];
	logic [DW-1:0]    regv_q [NREG];
	tag_t             regt_q [NREG];

	logic              out_valid_q, kind_q, last_q;
	logic [1:0]        status_q;
	logic [3:0]        station_q;
	logic [DW-1:0]     value_q;

	logic              slot_free, found, any_pend, later_pend, idx_last;
	tag_t              f_sel;
	int                lo, hi;
	logic [REG_W-1:0]  rd_addr;
	tag_t              rd_tag;
	logic [DW-1:0]     rd_val, a_sel, b_sel, prod, div_q;
	logic [LAT_W-1:0]  lat, lat_eff, cnt_nx;
	logic              div_done;
	tag_t              cur_tag;

	assign slot_free = !out_valid_q || out_ready;
	assign pop_ready = state_q == S_IDLE;
	assign idx_last  = idx_q == IDX_W'(NSTA - 1);
	assign cur_tag   = tag_t'(idx_q);
	assign rd_addr   = (state_q == S_RD1) ? cur_q.src1 : cur_q.src2;
	assign rd_tag    = regt_q[rd_addr];
	assign rd_val    = regv_q[rd_addr];
	assign a_sel     = opj_q[idx_q];
	assign b_sel     = opk_q[idx_q];
	assign prod      = a_sel * b_sel;
	assign cnt_nx    = cnt_q[idx_q] + 1'b1;
	assign lat_eff   = (lat == '0) ? LAT_W'(1) : lat;

	always_comb begin
		case (op_q[idx_q])
			OP_ADD, OP_SUB: lat = add_lat_q;
			OP_MUL:         lat = mul_lat_q;
			default:        lat = div_lat_q;
		endcase
	end

	always_comb begin
		case (cur_q.cls)
			CLS_ADD: begin
				lo = 0;
				hi = ADD_ST;
			end
			CLS_MUL: begin
				lo = ADD_ST;
				hi = ADD_ST + MUL_ST;
			end
			default: begin
				lo = ADD_ST + MUL_ST;
				hi = NSTA;
			end
		endcase
	end

	// Lowest free station of the class, and the stations still to broadcast.
	always_comb begin
		found      = 1'b0;
		f_sel      = '0;
		any_pend   = 1'b0;
		later_pend = 1'b0;
		for (int j = NSTA - 1; j >= 0; j--) begin
			if (j >= lo && j < hi && !busy_q[j]) begin
				found = 1'b1;
				f_sel = tag_t'(j);
			end
			if (rr_q[j] && ww_q[j]) begin
				any_pend = 1'b1;
				if (j > int'(idx_q)) begin
					later_pend = 1'b1;
				end
			end
		end
	end

	trs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.a      (a_sel),
		.b      (b_sel),
		.done   (div_done),
		.q      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			free_q      <= '0;
			div_start_q <= 1'b0;
			add_lat_q   <= LAT_W'(4);
			mul_lat_q   <= LAT_W'(12);
			div_lat_q   <= LAT_W'(38);
			out_valid_q <= 1'b0;
			for (int i = 0; i < NSTA; i++) begin
				busy_q[i] <= 1'b0;
				op_q[i]   <= '0;
				opj_q[i]  <= '0;
				opk_q[i]  <= '0;
				tj_q[i]   <= TAG_EMPTY;
				tk_q[i]   <= TAG_EMPTY;
				cnt_q[i]  <= '0;
				iw_q[i]   <= 1'b0;
				rr_q[i]   <= 1'b0;
				ww_q[i]   <= 1'b0;
				res_q[i]  <= '0;
			end
			for (int x = 0; x < NREG; x++) begin
				regv_q[x] <= (x == 0) ? DW'(100) : DW'(1);
				regt_q[x] <= TAG_READY;
			end
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					CFG_ADD_LAT: add_lat_q <= cfg.data;
					CFG_MUL_LAT: mul_lat_q <= cfg.data;
					CFG_DIV_LAT: div_lat_q <= cfg.data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (cur_q.vld && found) begin
						free_q  <= f_sel;
						state_q <= S_RD1;
					end else if (slot_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_ISSUE;
						status_q    <= cur_q.vld ? ST_STALL : ST_NONE;
						station_q   <= '0;
						value_q     <= '0;
						last_q      <= !any_pend;
						idx_q       <= '0;
						state_q     <= S_EXEC;
					end
				end
				S_RD1: begin
					if (rd_tag == TAG_READY) begin
						opj_q[free_q[IDX_W-1:0]] <= rd_val;
					end
					tj_q[free_q[IDX_W-1:0]] <= rd_tag;
					state_q <= S_RD2;
				end
				S_RD2: begin
					if (slot_free) begin
						if (rd_tag == TAG_READY) begin
							opk_q[free_q[IDX_W-1:0]] <= rd_val;
						end
						tk_q[free_q[IDX_W-1:0]]   <= rd_tag;
						busy_q[free_q[IDX_W-1:0]] <= 1'b1;
						op_q[free_q[IDX_W-1:0]]   <= cur_q.op;
						iw_q[free_q[IDX_W-1:0]]   <= 1'b0;
						regt_q[cur_q.dest]        <= free_q;
						out_valid_q <= 1'b1;
						kind_q      <= KIND_ISSUE;
						status_q    <= ST_ISSUED;
						station_q   <= free_q;
						value_q     <= '0;
						last_q      <= !any_pend;
						idx_q       <= '0;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (!busy_q[idx_q] || rr_q[idx_q]) begin
						idx_q   <= idx_last ? '0 : idx_q + 1'b1;
						state_q <= idx_last ? S_WB : S_EXEC;
					end else if (!iw_q[idx_q]) begin
						iw_q[idx_q] <= 1'b1;
						idx_q   <= idx_last ? '0 : idx_q + 1'b1;
						state_q <= idx_last ? S_WB : S_EXEC;
					end else if (tj_q[idx_q] != TAG_READY || tk_q[idx_q] != TAG_READY) begin
						idx_q   <= idx_last ? '0 : idx_q + 1'b1;
						state_q <= idx_last ? S_WB : S_EXEC;
					end else if (cnt_nx < lat_eff) begin
						cnt_q[idx_q] <= cnt_nx;
						idx_q   <= idx_last ? '0 : idx_q + 1'b1;
						state_q <= idx_last ? S_WB : S_EXEC;
					end else begin
						case (op_q[idx_q])
							OP_ADD, OP_SUB: begin
								res_q[idx_q] <= (op_q[idx_q] == OP_ADD) ?
									a_sel + b_sel : a_sel - b_sel;
								rr_q[idx_q]  <= 1'b1;
								cnt_q[idx_q] <= '0;
								iw_q[idx_q]  <= 1'b0;
								idx_q   <= idx_last ? '0 : idx_q + 1'b1;
								state_q <= idx_last ? S_WB : S_EXEC;
							end
							OP_MUL: begin
								mul_s1  <= prod;
								state_q <= S_MUL;
							end
							default: begin
								div_start_q <= 1'b1;
								state_q     <= S_DIVW;
							end
						endcase
					end
				end
				S_MUL: begin
					res_q[idx_q] <= mul_s1;
					rr_q[idx_q]  <= 1'b1;
					cnt_q[idx_q] <= '0;
					iw_q[idx_q]  <= 1'b0;
					idx_q   <= idx_last ? '0 : idx_q + 1'b1;
					state_q <= idx_last ? S_WB : S_EXEC;
				end
				S_DIVW: begin
					div_start_q <= 1'b0;
					if (div_done) begin
						res_q[idx_q] <= div_q;
						rr_q[idx_q]  <= 1'b1;
						cnt_q[idx_q] <= '0;
						iw_q[idx_q]  <= 1'b0;
						idx_q   <= idx_last ? '0 : idx_q + 1'b1;
						state_q <= idx_last ? S_WB : S_EXEC;
					end
				end
				S_WB: begin
					if (!rr_q[idx_q]) begin
						idx_q   <= idx_last ? '0 : idx_q + 1'b1;
						state_q <= idx_last ? S_IDLE : S_WB;
					end else if (!ww_q[idx_q]) begin
						ww_q[idx_q] <= 1'b1;
						idx_q   <= idx_last ? '0 : idx_q + 1'b1;
						state_q <= idx_last ? S_IDLE : S_WB;
					end else if (slot_free) begin
						for (int x = 0; x < NREG; x++) begin
							if (regt_q[x] == cur_tag) begin
								regv_q[x] <= res_q[idx_q];
								regt_q[x] <= TAG_READY;
							end
						end
						for (int y = 0; y < NSTA; y++) begin
							if (tj_q[y] == cur_tag) begin
								opj_q[y] <= res_q[idx_q];
								tj_q[y]  <= TAG_READY;
							end
							if (tk_q[y] == cur_tag) begin
								opk_q[y] <= res_q[idx_q];
								tk_q[y]  <= TAG_READY;
							end
						end
						rr_q[idx_q]   <= 1'b0;
						busy_q[idx_q] <= 1'b0;
						tj_q[idx_q]   <= TAG_EMPTY;
						tk_q[idx_q]   <= TAG_EMPTY;
						opj_q[idx_q]  <= '0;
						opk_q[idx_q]  <= '0;
						ww_q[idx_q]   <= 1'b0;
						out_valid_q <= 1'b1;
						kind_q      <= KIND_WB;
						status_q    <= ST_NONE;
						station_q   <= cur_tag;
						value_q     <= res_q[idx_q];
						last_q      <= !later_pend;
						idx_q   <= idx_last ? '0 : idx_q + 1'b1;
						state_q <= idx_last ? S_IDLE : S_WB;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop_valid) begin
			cur_q <= pop_item;
		end
	end

	assign out_valid    = out_valid_q;
	assign record_kind  = kind_q;
	assign issue_status = status_q;
	assign station      = station_q;
	assign value        = value_q;
	assign last         = last_q;

endmodule

// ===== hdl/tomasulo_reservation_scheduler_unit.sv =====
// Top level of the reservation station scheduler: front end, queue and sequencer.
// Each input transfer is one machine cycle and yields one issue report, then one
// broadcast record per station writing back; the sequencer visits the nine stations
// once to execute and once to broadcast, with an extra S_MUL step per multiply and a
// wait in S_DIVW on the iterative divider per divide that completes.
// Reset is asynchronous and immediate: stations empty, registers 100 and 1, latencies 4/12/38.
module tomasulo_reservation_scheduler_unit import trs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [LAT_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 instr_valid,
	input  logic [1:0]           opcode,
	input  logic [REG_W-1:0]     dest_reg,
	input  logic [REG_W-1:0]     src1_reg,
	input  logic [REG_W-1:0]     src2_reg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 record_kind,
	output logic [1:0]           issue_status,
	output logic [3:0]           station,
	output logic signed [DW-1:0] value,
	output logic                 last
);

	// The front end classifies each transfer and pushes it into the queue, so new items
	// are taken while the queue has room, even as the sequencer is busy with an earlier cycle.
	logic    push_valid, push_ready, pop_valid, pop_ready;
	item_t   push_item, pop_item;
	cfg_wr_t cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	trs_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.instr_valid (instr_valid),
		.opcode      (opcode),
		.dest_reg    (dest_reg),
		.src1_reg    (src1_reg),
		.src2_reg    (src2_reg),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	trs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// The sequencer owns the stations and the register file, and drives the
	// output register that holds one record until its transfer completes.
	trs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.record_kind  (record_kind),
		.issue_status (issue_status),
		.station      (station),
		.value        (value),
		.last         (last)
	);

`ifndef SYNTHESIS
	a_wb_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && record_kind == KIND_WB) |-> issue_status == ST_NONE)
		else $error("broadcast record carries an issue status");

	a_no_issue_station: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && record_kind == KIND_ISSUE && issue_status != ST_ISSUED)
		|-> (station == '0 && value == '0))
		else $error("issue report without issue names a station");

	a_wb_station_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && record_kind == KIND_WB) |-> station < 4'(NSTA))
		else $error("broadcast from a station that does not exist");
`endif

endmodule
